// File: hw/rtl/fcag_pkg.sv
// Shared types and constants for the frame checker and acknowledge generator.
// No dependencies; used by the channel interfaces and the top level.
package fcag_pkg;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_HEADER = 2'd1,
    ST_TAIL   = 2'd2,
    ST_PARITY = 2'd3
  } status_t;

  localparam logic [7:0] SYNC_A      = 8'hAA;
  localparam logic [7:0] SYNC_B      = 8'h55;
  localparam logic [7:0] ACK_LEN_B   = 8'h06;
  localparam logic [7:0] ACK_PAD     = 8'h00;
  localparam logic [7:0] LOCAL_ID_RST = 8'h20;
  localparam int unsigned ACK_BYTES  = 12;

  localparam logic [7:0] ID_ZERO  = 8'h00;
  localparam logic [7:0] ID_ONE   = 8'h01;
  localparam logic [7:0] ID_HOST  = 8'h20;
  localparam logic [7:0] TYPE_ZERO  = 8'h03;
  localparam logic [7:0] TYPE_ONE   = 8'hA7;
  localparam logic [7:0] TYPE_HOST  = 8'h72;
  localparam logic [7:0] TYPE_OTHER = 8'h00;

  function automatic logic [7:0] ack_type(input logic [7:0] id);
    logic [7:0] t;
    case (id)
      ID_ZERO: t = TYPE_ZERO;
      ID_ONE:  t = TYPE_ONE;
      ID_HOST: t = TYPE_HOST;
      default: t = TYPE_OTHER;
    endcase
    return t;
  endfunction

endpackage

// File: hw/rtl/fcag_if.sv
// Valid/ready channel interfaces: received bytes, results and id writes.
// Depends on fcag_pkg for the status type.
interface fcag_rx_if;
  logic       valid;
  logic       ready;
  logic       frame_start;
  logic [7:0] rx_byte;
  modport source (output valid, frame_start, rx_byte, input ready);
  modport sink   (input valid, frame_start, rx_byte, output ready);
endinterface

interface fcag_res_if;
  logic              valid;
  logic              ready;
  logic              kind;
  fcag_pkg::status_t status;
  logic [7:0]        ack_byte;
  logic              last;
  modport source (output valid, kind, status, ack_byte, last, input ready);
  modport sink   (input valid, kind, status, ack_byte, last, output ready);
endinterface

interface fcag_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] local_id;
  modport source (output valid, local_id, input ready);
  modport sink   (input valid, local_id, output ready);
endinterface

// File: hw/rtl/frame_checker_ack_generator.sv
// Frame checker and acknowledge generator, top level.
// Depends on fcag_pkg and the channel interfaces in fcag_if.sv.
//
// in_ch carries received bytes with a start-of-frame mark, one transaction
// per byte. Each byte is checked and folded into the frame state in the
// cycle it is taken, so a byte is accepted every cycle while no results
// are pending. Bytes that end a frame (or fail the header) queue a result
// run in the output register: one status transaction, then for a good frame
// with an ack request up to 12 ack frame bytes, last set on the final one.
// A run appears on out_ch the cycle after its byte; its results leave the
// single output register in order, and in_ch is held off until the last
// result of the run is taken (a new byte may enter in that same cycle).
// A receiver stall freezes the output register and, through it, in_ch.
// cfg_ch writes local_id at any time (always ready); write it only while
// idle. Reset (rst_n, synchronous, active low) closes any open frame, drops
// pending results and sets local_id to 0x20.
module frame_checker_ack_generator (
  input  logic         clk,
  input  logic         rst_n,
  fcag_rx_if.sink      in_ch,
  fcag_res_if.source   out_ch,
  fcag_cfg_if.sink     cfg_ch
);

  logic [7:0] local_id_r;
  logic       active_r, active_nxt;
  logic [8:0] position_r, position_nxt;
  logic [7:0] length_r, length_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic       ack_wanted_r, ack_wanted_nxt;
  logic [7:0] source_r, source_nxt;
  logic [7:0] rx_par_r, rx_par_nxt;
  logic       par_ok_r, par_ok_nxt;
  logic       tail1_ok_r, tail1_ok_nxt;

  logic              busy_r, busy_nxt;
  logic [3:0]        seq_r, seq_nxt;
  fcag_pkg::status_t st_r, st_nxt;
  logic              ack_job_r, ack_job_nxt;

  logic              in_acc, out_acc, out_last;
  logic              job_new, job_ack;
  fcag_pkg::status_t job_st;
  logic              frm_open;
  logic [8:0]        pos;
  logic [9:0]        pos_ext, len_ext;
  logic [7:0]        b;
  logic              tail_ok;
  fcag_pkg::status_t fin_st;

  logic [7:0] ack_type_v, chk, cur_b, prev_b;
  logic [3:0] cur_idx, prev_idx;
  logic       stop;

  function automatic logic [7:0] ack_at(input logic [3:0] idx, input logic [7:0] lid,
                                        input logic [7:0] src, input logic [7:0] typ,
                                        input logic [7:0] len, input logic [7:0] rpar,
                                        input logic [7:0] ck);
    logic [7:0] v;
    case (idx)
      4'd0:    v = fcag_pkg::SYNC_A;
      4'd1:    v = fcag_pkg::SYNC_B;
      4'd2:    v = fcag_pkg::ACK_LEN_B;
      4'd3:    v = lid;
      4'd4:    v = src;
      4'd5:    v = fcag_pkg::ACK_PAD;
      4'd6:    v = typ;
      4'd7:    v = len;
      4'd8:    v = rpar;
      4'd9:    v = ck;
      4'd10:   v = fcag_pkg::SYNC_B;
      4'd11:   v = fcag_pkg::SYNC_A;
      default: v = fcag_pkg::ACK_PAD;
    endcase
    return v;
  endfunction

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_id_r <= fcag_pkg::LOCAL_ID_RST;
    end else if (cfg_ch.valid) begin
      local_id_r <= cfg_ch.local_id;
    end
  end

  // Result run: status at seq 0, ack byte seq-1 after it
  assign ack_type_v = fcag_pkg::ack_type(local_id_r);
  assign chk = fcag_pkg::ACK_LEN_B ^ local_id_r ^ source_r ^ fcag_pkg::ACK_PAD ^
               ack_type_v ^ length_r ^ rx_par_r;
  assign cur_idx  = seq_r - 4'd1;
  assign prev_idx = seq_r - 4'd2;
  assign cur_b  = ack_at(cur_idx, local_id_r, source_r, ack_type_v, length_r, rx_par_r, chk);
  assign prev_b = ack_at(prev_idx, local_id_r, source_r, ack_type_v, length_r, rx_par_r, chk);
  assign stop = (seq_r >= 4'd2) && (cur_b == fcag_pkg::SYNC_A) &&
                (prev_b == fcag_pkg::SYNC_B);
  assign out_last = (seq_r == 4'd0) ? !ack_job_r
                  : (stop || (seq_r == 4'(fcag_pkg::ACK_BYTES)));

  assign out_ch.valid    = busy_r;
  assign out_ch.kind     = (seq_r != 4'd0);
  assign out_ch.status   = (seq_r == 4'd0) ? st_r : fcag_pkg::ST_OK;
  assign out_ch.ack_byte = (seq_r == 4'd0) ? 8'h00 : cur_b;
  assign out_ch.last     = out_last;

  assign out_acc     = busy_r && out_ch.ready;
  assign in_ch.ready = !busy_r || (out_ch.ready && out_last);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Frame checking
  assign b        = in_ch.rx_byte;
  assign frm_open = in_ch.frame_start || active_r;
  assign pos      = in_ch.frame_start ? 9'd0 : position_r;
  assign pos_ext  = {1'b0, pos};
  assign len_ext  = {2'b00, length_r};
  assign tail_ok  = tail1_ok_r && (b == fcag_pkg::SYNC_A);
  assign fin_st   = !tail_ok ? fcag_pkg::ST_TAIL
                  : (!par_ok_r ? fcag_pkg::ST_PARITY : fcag_pkg::ST_OK);

  always_comb begin
    active_nxt     = active_r;
    position_nxt   = position_r;
    length_nxt     = length_r;
    xor_nxt        = xor_r;
    ack_wanted_nxt = ack_wanted_r;
    source_nxt     = source_r;
    rx_par_nxt     = rx_par_r;
    par_ok_nxt     = par_ok_r;
    tail1_ok_nxt   = tail1_ok_r;
    job_new        = 1'b0;
    job_st         = fcag_pkg::ST_OK;
    job_ack        = 1'b0;
    if (in_acc && frm_open) begin
      active_nxt   = 1'b1;
      position_nxt = pos + 9'd1;
      if (pos == 9'd0 || pos == 9'd1) begin
        if (b != ((pos == 9'd0) ? fcag_pkg::SYNC_A : fcag_pkg::SYNC_B)) begin
          job_new      = 1'b1;
          job_st       = fcag_pkg::ST_HEADER;
          active_nxt   = 1'b0;
          position_nxt = pos;
        end
      end else if (pos == 9'd2) begin
        length_nxt = b;
        xor_nxt    = b;
      end else begin
        if (pos == 9'd3) begin
          source_nxt = b;
        end
        if (pos == 9'd5) begin
          ack_wanted_nxt = (b != 8'h00);
        end
        if (pos_ext <= len_ext + 10'd2) begin
          xor_nxt = xor_r ^ b;
        end else if (pos_ext == len_ext + 10'd3) begin
          rx_par_nxt = b;
          par_ok_nxt = (xor_r == b);
        end else if (pos_ext == len_ext + 10'd4) begin
          tail1_ok_nxt = (b == fcag_pkg::SYNC_B);
        end else begin
          active_nxt   = 1'b0;
          position_nxt = 9'd0;
          job_new      = 1'b1;
          job_st       = fin_st;
          job_ack      = (fin_st == fcag_pkg::ST_OK) && ack_wanted_nxt;
        end
      end
    end
  end

  always_comb begin
    busy_nxt    = busy_r;
    seq_nxt     = seq_r;
    st_nxt      = st_r;
    ack_job_nxt = ack_job_r;
    if (job_new) begin
      busy_nxt    = 1'b1;
      seq_nxt     = 4'd0;
      st_nxt      = job_st;
      ack_job_nxt = job_ack;
    end else if (out_acc) begin
      if (out_last) begin
        busy_nxt = 1'b0;
      end else begin
        seq_nxt = seq_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b0;
      position_r   <= '0;
      length_r     <= '0;
      xor_r        <= '0;
      ack_wanted_r <= 1'b0;
      source_r     <= '0;
      rx_par_r     <= '0;
      par_ok_r     <= 1'b0;
      tail1_ok_r   <= 1'b0;
      busy_r       <= 1'b0;
      seq_r        <= '0;
      st_r         <= fcag_pkg::ST_OK;
      ack_job_r    <= 1'b0;
    end else begin
      active_r     <= active_nxt;
      position_r   <= position_nxt;
      length_r     <= length_nxt;
      xor_r        <= xor_nxt;
      ack_wanted_r <= ack_wanted_nxt;
      source_r     <= source_nxt;
      rx_par_r     <= rx_par_nxt;
      par_ok_r     <= par_ok_nxt;
      tail1_ok_r   <= tail1_ok_nxt;
      busy_r       <= busy_nxt;
      seq_r        <= seq_nxt;
      st_r         <= st_nxt;
      ack_job_r    <= ack_job_nxt;
    end
  end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// Testbench for frame_checker_ack_generator: directed and random frames with a
// predicting scoreboard that checks every status and ack transaction in order.
// Depends on fcag_pkg, the channel interfaces in fcag_if.sv and the top level.
module tb_top;
  import fcag_pkg::*;

  typedef struct packed {
    logic       kind;
    status_t    status;
    logic [7:0] ack_byte;
    logic       last;
  } result_t;

  typedef enum {
    FR_GOOD,
    FR_BAD_PARITY,
    FR_BAD_TAIL,
    FR_BAD_BOTH,
    FR_BAD_HEADER,
    FR_CUT_SHORT,
    FR_STRAY_MARK
  } flavour_t;

  localparam int unsigned IDLE_LIMIT = 5000;

  class frame_scoreboard;
    logic [7:0] own_id;
    logic       active;
    logic [8:0] position;
    logic [7:0] frame_length;
    logic [7:0] running_xor;
    logic       ack_wanted;
    logic [7:0] source_id;
    logic [7:0] received_parity;
    logic       parity_ok;
    logic       tail_first_ok;
    result_t    due_results[$];
    int         errors;

    function new();
      own_id          = LOCAL_ID_RST;
      active          = 1'b0;
      position        = '0;
      frame_length    = '0;
      running_xor     = '0;
      ack_wanted      = 1'b0;
      source_id       = '0;
      received_parity = '0;
      parity_ok       = 1'b0;
      tail_first_ok   = 1'b0;
      errors          = 0;
    endfunction

    function void set_id(logic [7:0] id);
      own_id = id;
    endfunction

    function logic [7:0] type_code(logic [7:0] id);
      if (id == ID_ZERO) return TYPE_ZERO;
      if (id == ID_ONE) return TYPE_ONE;
      if (id == ID_HOST) return TYPE_HOST;
      return TYPE_OTHER;
    endfunction

    function void take_rx_byte(logic start, logic [7:0] b);
      int unsigned pos;
      int unsigned len;
      logic        tail_ok;
      status_t     st;
      logic [7:0]  ack [ACK_BYTES];
      logic [7:0]  chk;
      result_t     r;
      result_t     run[$];
      if (start) begin
        active   = 1'b1;
        position = '0;
      end
      if (!active) return;
      pos = 32'(position);
      len = 32'(frame_length);
      if (pos < 2) begin
        if (b != ((pos == 0) ? SYNC_A : SYNC_B)) begin
          r        = '0;
          r.status = ST_HEADER;
          r.last   = 1'b1;
          due_results.push_back(r);
          active = 1'b0;
        end else begin
          position = position + 9'd1;
        end
        return;
      end
      if (pos == 2) begin
        frame_length = b;
        running_xor  = b;
        position     = 9'd3;
        return;
      end
      if (pos == 3) source_id = b;
      if (pos == 5) ack_wanted = (b != 8'h00);
      if (pos <= len + 2) begin
        running_xor ^= b;
      end else if (pos == len + 3) begin
        received_parity = b;
        parity_ok       = (running_xor == b);
      end else if (pos == len + 4) begin
        tail_first_ok = (b == SYNC_B);
      end else begin
        tail_ok  = tail_first_ok && (b == SYNC_A);
        active   = 1'b0;
        position = '0;
        if (!tail_ok) st = ST_TAIL;
        else if (!parity_ok) st = ST_PARITY;
        else st = ST_OK;
        r        = '0;
        r.status = st;
        run.push_back(r);
        if (st == ST_OK && ack_wanted) begin
          ack[0] = SYNC_A;
          ack[1] = SYNC_B;
          ack[2] = ACK_LEN_B;
          ack[3] = own_id;
          ack[4] = source_id;
          ack[5] = ACK_PAD;
          ack[6] = type_code(own_id);
          ack[7] = frame_length;
          ack[8] = received_parity;
          chk    = ACK_LEN_B;
          for (int i = 3; i < 9; i++) chk ^= ack[i];
          ack[9]  = chk;
          ack[10] = SYNC_B;
          ack[11] = SYNC_A;
          for (int i = 0; i < ACK_BYTES; i++) begin
            r          = '0;
            r.kind     = 1'b1;
            r.ack_byte = ack[i];
            run.push_back(r);
            if (i > 0 && ack[i] == SYNC_A && ack[i-1] == SYNC_B) break;
          end
        end
        run[run.size()-1].last = 1'b1;
        foreach (run[i]) due_results.push_back(run[i]);
        return;
      end
      position = position + 9'd1;
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result kind %0h status %0h byte %0h last %0h",
                 $time, got.kind, got.status, got.ack_byte, got.last);
        return;
      end
      want = due_results.pop_front();
      compare_field("kind", 8'(want.kind), 8'(got.kind));
      compare_field("status", 8'(want.status), 8'(got.status));
      compare_field("ack_byte", want.ack_byte, got.ack_byte);
      compare_field("last", 8'(want.last), 8'(got.last));
    endfunction
  endclass

  logic clk;
  logic rst_n;

  fcag_rx_if  in_ch();
  fcag_res_if out_ch();
  fcag_cfg_if cfg_ch();

  frame_checker_ack_generator DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  frame_scoreboard sb;
  bit              quiet;
  int unsigned     sent_bytes;
  int unsigned     idle_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return SYNC_A;
    if (r < 30) return SYNC_B;
    if (r < 35) return 8'h00;
    if (r < 40) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] nonzero();
    return 8'($urandom_range(1, 255));
  endfunction

  // hold ready low for random stretches
  initial begin
    int unsigned stall;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!quiet && $urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n === 1'b1) begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        sb.check_result({out_ch.kind, out_ch.status, out_ch.ack_byte, out_ch.last});
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
          (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_byte(input logic start, input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.frame_start <= start;
    in_ch.rx_byte     <= b;
    do @(negedge clk); while (in_ch.ready !== 1'b1);
    @(posedge clk);
    sb.take_rx_byte(start, b);
    sent_bytes++;
  endtask

  task automatic write_local_id(input logic [7:0] id);
    in_ch.valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_ch.valid    <= 1'b1;
    cfg_ch.local_id <= id;
    do @(negedge clk); while (cfg_ch.ready !== 1'b1);
    @(posedge clk);
    cfg_ch.valid <= 1'b0;
    sb.set_id(id);
  endtask

  task automatic send_frame(input int unsigned len, input flavour_t how);
    logic [7:0]  fr[$];
    logic [7:0]  par;
    int unsigned stop;
    int unsigned mark;
    int unsigned k;
    fr = {};
    fr.push_back(SYNC_A);
    fr.push_back(SYNC_B);
    fr.push_back(len[7:0]);
    for (int i = 0; i < len; i++) fr.push_back(pick_byte());
    if (len >= 3 && $urandom_range(0, 3) == 0) fr[5] = 8'h00;
    par = len[7:0];
    for (int i = 3; i < len + 3; i++) par ^= fr[i];
    // steer the parity to AA so that in the ack it directly follows a length of 55
    if (len == 8'h55 && $urandom_range(0, 1) == 1) begin
      fr[len+2] ^= par ^ SYNC_A;
      par = SYNC_A;
    end
    fr.push_back(par);
    fr.push_back(SYNC_B);
    fr.push_back(SYNC_A);
    stop = fr.size();
    mark = fr.size();
    case (how)
      FR_BAD_PARITY: fr[len+3] ^= nonzero();
      FR_BAD_TAIL: begin
        k = $urandom_range(0, 1);
        fr[len+4+k] ^= nonzero();
      end
      FR_BAD_BOTH: begin
        k = $urandom_range(0, 1);
        fr[len+3] ^= nonzero();
        fr[len+4+k] ^= nonzero();
      end
      FR_BAD_HEADER: begin
        k = $urandom_range(0, 1);
        fr[k] ^= nonzero();
        stop = k + 1;
      end
      FR_CUT_SHORT: stop = $urandom_range(1, fr.size() - 1);
      FR_STRAY_MARK: mark = $urandom_range(1, fr.size() - 1);
      default: ;
    endcase
    for (int i = 0; i < stop; i++) send_byte(i == 0 || i == mark, fr[i]);
  endtask

  task automatic random_traffic(input int unsigned until_bytes);
    int unsigned r;
    int unsigned len;
    flavour_t    how;
    while (sent_bytes < until_bytes) begin
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(0, 8);
      else if (r < 93) len = $urandom_range(9, 40);
      else if (r < 97) len = $urandom_range(41, 120);
      else len = 32'h55;
      r = $urandom_range(0, 99);
      if (r < 55) how = FR_GOOD;
      else if (r < 63) how = FR_BAD_PARITY;
      else if (r < 71) how = FR_BAD_TAIL;
      else if (r < 76) how = FR_BAD_BOTH;
      else if (r < 84) how = FR_BAD_HEADER;
      else if (r < 92) how = FR_CUT_SHORT;
      else how = FR_STRAY_MARK;
      send_frame(len, how);
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 3)) send_byte(1'b0, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    logic [8:0] opening[$];
    sb          = new();
    quiet       = 1'b0;
    sent_bytes  = 0;
    idle_cycles = 0;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.frame_start <= 1'b0;
    in_ch.rx_byte     <= 8'h00;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.local_id   <= 8'h00;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    opening = '{
      {1'b0, 8'h3C},
      {1'b1, 8'h5A},
      {1'b1, SYNC_A}, {1'b0, 8'h00},
      {1'b1, SYNC_A}, {1'b0, SYNC_B}, {1'b0, 8'h00}, {1'b0, 8'h00},
      {1'b0, SYNC_B}, {1'b0, SYNC_A},
      {1'b1, SYNC_A}, {1'b0, SYNC_B}, {1'b0, 8'h00}, {1'b0, 8'h01},
      {1'b0, SYNC_B}, {1'b0, SYNC_A},
      {1'b1, SYNC_A}, {1'b0, SYNC_B}, {1'b0, 8'h07},
      {1'b1, SYNC_A}, {1'b0, SYNC_B}, {1'b0, 8'h01}, {1'b0, 8'hFF},
      {1'b0, 8'h00}, {1'b0, SYNC_B}, {1'b0, 8'h00}
    };
    foreach (opening[i]) send_byte(opening[i][8], opening[i][7:0]);

    random_traffic(sent_bytes + 40);
    write_local_id(ID_ZERO);
    random_traffic(sent_bytes + 35);
    write_local_id(8'hFF);
    quiet = 1'b1;
    random_traffic(sent_bytes + 25);
    quiet = 1'b0;
    write_local_id(ID_ONE);
    random_traffic(sent_bytes + 35);
    write_local_id(8'h55);
    random_traffic(sent_bytes + 35);
    write_local_id(8'($urandom_range(0, 255)));
    random_traffic(sent_bytes + 25);
    write_local_id(ID_HOST);
    random_traffic(sent_bytes + 25);

    in_ch.valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.errors == 0 && sb.due_results.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
